/* design/usm_pkg.sv */
package usm_pkg;

    // Image geometry
    localparam int WIDTH  = 256;
    localparam int HEIGHT = 256;

    localparam int COL_W = $clog2(WIDTH);
    localparam int ROW_W = $clog2(HEIGHT + 2);
    localparam int CNT_W = $clog2(WIDTH * HEIGHT + 1);

    // Configuration register map
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO = 2'd1;

    localparam logic [7:0]  BASE_RST  = 8'd8;
    localparam logic [10:0] RATIO_RST = 11'd666;
    localparam logic [10:0] RATIO_MIN = 11'd513;

    // Shared divider: 8 quotient bits, dividend up to 25 bits
    localparam int DIV_W     = 25;
    localparam int DIV_STEPS = 8;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef struct packed {
        logic take;
        logic zero_pix;
        logic rd_en;
        logic shift;
        logic mul;
        logic div_load_low;
        logic div_load_out;
        logic div_step;
        logic num1;
        logic num2;
        logic load_out;
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
        logic last;
    } usm_cmd_t;

endpackage

/* design/unsharp_mask_sharpener.sv */
// Unsharp-mask sharpener for a raster stream of 8-bit gray pixels.
// Input channel (in_valid/in_ready, mode, pixel_in): mode 0 is a pixel in
// raster order, mode 1 a flush word. After the last pixel of a frame, send
// WIDTH+1 flush words to drain; a flush word sent earlier is dropped.
// Output channel (out_valid/out_ready, pixel_out, frame_last): one word per
// produced pixel, frame_last marks the final pixel of the frame.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 is the
// low-pass weight base, index 1 the sharpen ratio in Q10. Always ready;
// write only while the block is idle.
// Timing: one word at a time. A word with no result passes the line store
// read and window shift; a word with a result adds weight multiply, shared
// 8-step low-pass division, ratio multiply, shared 8-step output division;
// then in_ready returns. Results appear one row plus one pixel behind inputs.
// Reset clears the position counters and the output valid flag; line stores
// and the tap window are not cleared, their stale taps never reach a result.
// A result waiting in the output register does not block the next word; a
// second result holds in the final state until the receiver takes the first.
module unsharp_mask_sharpener (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            mode,
    input  logic [7:0]                      pixel_in,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      pixel_out,
    output logic                            frame_last,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [usm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [usm_pkg::CFG_DAT_W-1:0]   cfg_data
);

    usm_pkg::usm_cmd_t           cmd;
    logic [usm_pkg::COL_W-1:0]   col;

    // config registers never stall
    assign cfg_ready = 1'b1;

    usm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .mode      (mode),
        .out_ready (out_ready),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .col       (col),
        .cmd       (cmd)
    );

    usm_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .col        (col),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pixel_in   (pixel_in),
        .pixel_out  (pixel_out),
        .frame_last (frame_last)
    );

    // never overwrite a word the receiver has not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid || out_ready))
        else $error("output word overwritten");

    // line store read is always followed by the window shift
    a_read_shift: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |=> cmd.shift)
        else $error("window shift missing after line read");

    // a new word is only taken while no computation is in flight
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step || cmd.mul || cmd.num1 || cmd.num2) |-> !in_ready)
        else $error("input accepted during computation");

endmodule

/* design/usm_div.sv */
module usm_div (
    input  logic                        clk,
    input  logic                        load,
    input  logic                        step,
    input  logic [usm_pkg::DIV_W-1:0]   dividend,
    input  logic [usm_pkg::DIV_W-1:0]   divisor,
    output logic [7:0]                  quotient
);

    logic [usm_pkg::DIV_W-1:0] rem_reg;
    logic [usm_pkg::DIV_W-1:0] dsh_reg;
    logic [7:0]                quo_reg;

    // restoring divide, one quotient bit per step, divisor pre-shifted by 7
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= dividend;
            dsh_reg <= divisor << (usm_pkg::DIV_STEPS - 1);
            quo_reg <= '0;
        end
        else if (step)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                quo_reg <= {quo_reg[6:0], 1'b1};
            end
            else
            begin
                quo_reg <= {quo_reg[6:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign quotient = quo_reg;

endmodule

/* design/usm_datapath.sv */
module usm_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  usm_pkg::usm_cmd_t               cmd,
    input  logic [usm_pkg::COL_W-1:0]       col,
    input  logic                            cfg_valid,
    input  logic [usm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [usm_pkg::CFG_DAT_W-1:0]   cfg_data,
    input  logic [7:0]                      pixel_in,
    output logic [7:0]                      pixel_out,
    output logic                            frame_last
);

    logic [7:0]  base_reg;
    logic [10:0] ratio_reg;
    logic [15:0] b2_reg;

    logic [7:0] upper_mem  [usm_pkg::WIDTH];
    logic [7:0] middle_mem [usm_pkg::WIDTH];
    logic [7:0] up_rd_reg;
    logic [7:0] mid_rd_reg;
    logic [7:0] pix_reg;

    logic [7:0] win_reg [3][3];
    logic [7:0] tap_reg [3][3];
    logic [7:0] new_col [3];

    logic [9:0]  corner_sum;
    logic [9:0]  edge_sum;
    logic [2:0]  n_corner;
    logic [2:0]  n_edge;
    logic [24:0] sum_reg;
    logic [16:0] wt_reg;
    logic [7:0]  p_reg;

    logic [7:0]          low;
    logic [10:0]         qc;
    logic signed [11:0]  coef;
    logic [18:0]         prod_a_reg;
    logic signed [20:0]  prod_b_reg;
    logic [11:0]         den_reg;
    logic signed [21:0]  num;
    logic [19:0]         num_reg;
    logic                neg_reg;
    logic                sat_reg;

    logic                        div_load;
    logic [usm_pkg::DIV_W-1:0]   div_a;
    logic [usm_pkg::DIV_W-1:0]   div_b;
    logic [7:0]                  quo;

    logic [7:0] pixel_out_reg;
    logic       frame_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= usm_pkg::BASE_RST;
            ratio_reg <= usm_pkg::RATIO_RST;
            b2_reg    <= 16'(usm_pkg::BASE_RST * usm_pkg::BASE_RST);
        end
        else
        begin
            if (cfg_valid && cfg_index == usm_pkg::CFG_BASE)
                base_reg <= cfg_data[7:0];
            if (cfg_valid && cfg_index == usm_pkg::CFG_RATIO)
                ratio_reg <= cfg_data;
            b2_reg <= base_reg * base_reg;
        end
    end

    // line stores
    always_ff @(posedge clk)
    begin
        if (cmd.take)
            pix_reg <= cmd.zero_pix ? 8'd0 : pixel_in;
        if (cmd.rd_en)
        begin
            up_rd_reg  <= upper_mem[col];
            mid_rd_reg <= middle_mem[col];
        end
        if (cmd.shift)
        begin
            upper_mem[col]  <= mid_rd_reg;
            middle_mem[col] <= pix_reg;
        end
    end

    assign new_col[0] = up_rd_reg;
    assign new_col[1] = mid_rd_reg;
    assign new_col[2] = pix_reg;

    // window shift; taps are old cols 1,2 plus incoming column
    always_ff @(posedge clk)
    begin
        if (cmd.shift)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
                win_reg[r][2] <= new_col[r];
                tap_reg[r][0] <= win_reg[r][1];
                tap_reg[r][1] <= win_reg[r][2];
                tap_reg[r][2] <= new_col[r];
            end
        end
    end

    always_comb
    begin
        corner_sum = ((cmd.top_ok && cmd.left_ok)  ? 10'(tap_reg[0][0]) : 10'd0)
                   + ((cmd.top_ok && cmd.right_ok) ? 10'(tap_reg[0][2]) : 10'd0)
                   + ((cmd.bot_ok && cmd.left_ok)  ? 10'(tap_reg[2][0]) : 10'd0)
                   + ((cmd.bot_ok && cmd.right_ok) ? 10'(tap_reg[2][2]) : 10'd0);
        edge_sum   = (cmd.top_ok   ? 10'(tap_reg[0][1]) : 10'd0)
                   + (cmd.bot_ok   ? 10'(tap_reg[2][1]) : 10'd0)
                   + (cmd.left_ok  ? 10'(tap_reg[1][0]) : 10'd0)
                   + (cmd.right_ok ? 10'(tap_reg[1][2]) : 10'd0);
        n_corner   = 3'(cmd.top_ok && cmd.left_ok) + 3'(cmd.top_ok && cmd.right_ok)
                   + 3'(cmd.bot_ok && cmd.left_ok) + 3'(cmd.bot_ok && cmd.right_ok);
        n_edge     = 3'(cmd.top_ok) + 3'(cmd.bot_ok) + 3'(cmd.left_ok) + 3'(cmd.right_ok);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            sum_reg <= 25'(corner_sum) + 25'(edge_sum) * 25'(base_reg)
                     + 25'(tap_reg[1][1]) * 25'(b2_reg);
            wt_reg  <= 17'(n_corner) + 17'(n_edge) * 17'(base_reg) + 17'(b2_reg);
            p_reg   <= tap_reg[1][1];
        end
    end

    assign low  = (wt_reg == '0) ? p_reg : quo;
    assign qc   = (ratio_reg < usm_pkg::RATIO_MIN) ? usm_pkg::RATIO_MIN : ratio_reg;
    assign coef = $signed(12'd1024 - {1'b0, qc});
    assign num  = $signed({3'b000, prod_a_reg}) - 22'(prod_b_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.num1)
        begin
            prod_a_reg <= qc * p_reg;
            prod_b_reg <= coef * $signed({1'b0, low});
            den_reg    <= {qc, 1'b0} - 12'd1024;
        end
        if (cmd.num2)
        begin
            neg_reg <= num[21];
            sat_reg <= num[20:0] >= 21'({den_reg, 8'd0});
            num_reg <= num[19:0];
        end
    end

    assign div_load = cmd.div_load_low || cmd.div_load_out;
    assign div_a    = cmd.div_load_low ? sum_reg : 25'(num_reg);
    assign div_b    = cmd.div_load_low ? 25'(wt_reg) : 25'(den_reg);

    usm_div u_div (
        .clk      (clk),
        .load     (div_load),
        .step     (cmd.div_step),
        .dividend (div_a),
        .divisor  (div_b),
        .quotient (quo)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            pixel_out_reg  <= neg_reg ? 8'd0 : (sat_reg ? 8'd255 : quo);
            frame_last_reg <= cmd.last;
        end
    end

    assign pixel_out  = pixel_out_reg;
    assign frame_last = frame_last_reg;

endmodule

/* design/usm_ctrl.sv */
module usm_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        mode,
    input  logic                        out_ready,
    output logic                        in_ready,
    output logic                        out_valid,
    output logic [usm_pkg::COL_W-1:0]   col,
    output usm_pkg::usm_cmd_t           cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_SHIFT, S_MUL, S_LLOAD, S_LDIV,
        S_NUM1, S_NUM2, S_OLOAD, S_ODIV, S_DONE
    } state_t;

    state_t                      state_reg;
    logic [usm_pkg::COL_W-1:0]   x_reg;
    logic [usm_pkg::ROW_W-1:0]   r_reg;
    logic [usm_pkg::CNT_W-1:0]   cnt_reg;
    logic [usm_pkg::COL_W-1:0]   addr_reg;
    logic [usm_pkg::STEP_W-1:0]  step_reg;
    logic produced_reg, last_reg, out_valid_reg;
    logic top_reg, bot_reg, left_reg, right_reg;

    logic draining, work, case_a, case_b, produced, wrap, cnt_last, out_free;

    always_comb
    begin
        draining = r_reg >= usm_pkg::ROW_W'(usm_pkg::HEIGHT);
        work     = in_valid && state_reg == S_IDLE && (draining || !mode);
        case_a   = x_reg == '0 && r_reg >= usm_pkg::ROW_W'(2);
        case_b   = x_reg != '0 && r_reg >= usm_pkg::ROW_W'(1);
        produced = case_a || case_b;
        wrap     = x_reg == usm_pkg::COL_W'(usm_pkg::WIDTH - 1);
        cnt_last = cnt_reg == usm_pkg::CNT_W'(usm_pkg::WIDTH * usm_pkg::HEIGHT - 1);
        out_free = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            x_reg         <= '0;
            r_reg         <= '0;
            cnt_reg       <= '0;
            addr_reg      <= '0;
            step_reg      <= '0;
            produced_reg  <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            top_reg       <= 1'b0;
            bot_reg       <= 1'b0;
            left_reg      <= 1'b0;
            right_reg     <= 1'b0;
        end
        else
        begin
            // a word taken while the next one loads keeps valid high
            if (out_valid_reg && out_ready && !(state_reg == S_DONE && out_free))
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (work)
                    begin
                        addr_reg     <= x_reg;
                        produced_reg <= produced;
                        last_reg     <= produced && cnt_last;
                        top_reg      <= case_a ? (r_reg >= usm_pkg::ROW_W'(3))
                                               : (r_reg >= usm_pkg::ROW_W'(2));
                        bot_reg      <= case_a ? (r_reg <= usm_pkg::ROW_W'(usm_pkg::HEIGHT))
                                               : (r_reg <  usm_pkg::ROW_W'(usm_pkg::HEIGHT));
                        left_reg     <= case_a || x_reg >= usm_pkg::COL_W'(2);
                        right_reg    <= case_b;
                        if (produced && cnt_last)
                        begin
                            x_reg   <= '0;
                            r_reg   <= '0;
                            cnt_reg <= '0;
                        end
                        else
                        begin
                            x_reg <= wrap ? '0 : x_reg + 1'b1;
                            if (wrap)
                                r_reg <= r_reg + 1'b1;
                            if (produced)
                                cnt_reg <= cnt_reg + 1'b1;
                        end
                        state_reg <= S_READ;
                    end
                end
                S_READ:  state_reg <= S_SHIFT;
                S_SHIFT: state_reg <= produced_reg ? S_MUL : S_IDLE;
                S_MUL:   state_reg <= S_LLOAD;
                S_LLOAD:
                begin
                    step_reg  <= '0;
                    state_reg <= S_LDIV;
                end
                S_LDIV:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == usm_pkg::STEP_W'(usm_pkg::DIV_STEPS - 1))
                        state_reg <= S_NUM1;
                end
                S_NUM1: state_reg <= S_NUM2;
                S_NUM2: state_reg <= S_OLOAD;
                S_OLOAD:
                begin
                    step_reg  <= '0;
                    state_reg <= S_ODIV;
                end
                S_ODIV:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == usm_pkg::STEP_W'(usm_pkg::DIV_STEPS - 1))
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        cmd              = '0;
        cmd.take         = work;
        cmd.zero_pix     = draining;
        cmd.rd_en        = state_reg == S_READ;
        cmd.shift        = state_reg == S_SHIFT;
        cmd.mul          = state_reg == S_MUL;
        cmd.div_load_low = state_reg == S_LLOAD;
        cmd.div_load_out = state_reg == S_OLOAD;
        cmd.div_step     = state_reg == S_LDIV || state_reg == S_ODIV;
        cmd.num1         = state_reg == S_NUM1;
        cmd.num2         = state_reg == S_NUM2;
        cmd.load_out     = state_reg == S_DONE && out_free;
        cmd.top_ok       = top_reg;
        cmd.bot_ok       = bot_reg;
        cmd.left_ok      = left_reg;
        cmd.right_ok     = right_reg;
        cmd.last         = last_reg;
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
    assign col       = addr_reg;

endmodule

/* test/unsharp_mask_sharpener_test.sv */
`timescale 1ns / 100ps

// Sharpening predictor and result checker for the unsharp-mask block.
class sharpen_board;
    int unsigned base_b;
    int unsigned ratio_q;
    logic [7:0]  upper [usm_pkg::WIDTH];
    logic [7:0]  middle [usm_pkg::WIDTH];
    logic [7:0]  win [9];
    int unsigned col;
    int unsigned row;
    int unsigned produced_cnt;
    logic [7:0]  pix_due [$];
    bit          last_due [$];
    int unsigned mismatches;

    function void clear();
        base_b = usm_pkg::BASE_RST;
        ratio_q = usm_pkg::RATIO_RST;
        foreach (upper[i]) upper[i] = '0;
        foreach (middle[i]) middle[i] = '0;
        foreach (win[i]) win[i] = '0;
        col = 0;
        row = 0;
        produced_cnt = 0;
        mismatches = 0;
    endfunction

    function void set_reg(logic [usm_pkg::CFG_IDX_W-1:0] idx,
                          logic [usm_pkg::CFG_DAT_W-1:0] val);
        if (idx == usm_pkg::CFG_BASE)
            base_b = val[7:0];
        else if (idx == usm_pkg::CFG_RATIO)
            ratio_q = val;
    endfunction

    // Weighted 3x3 low-pass, then the unsharp combination.
    function logic [7:0] sharpen_at(int ccol, int orow, int ocol);
        int unsigned sum, wsum, w, p, low;
        int rr, cc, wc, q, num, den, res;
        sum = 0;
        wsum = 0;
        for (int dr = -1; dr <= 1; dr++)
        begin
            rr = orow + dr;
            if (rr < 0 || rr >= usm_pkg::HEIGHT)
                continue;
            for (int dc = -1; dc <= 1; dc++)
            begin
                cc = ocol + dc;
                wc = ccol + dc;
                if (cc < 0 || cc >= usm_pkg::WIDTH || wc < 0 || wc > 2)
                    continue;
                if (dr != 0 && dc != 0)
                    w = 1;
                else if (dr == 0 && dc == 0)
                    w = base_b * base_b;
                else
                    w = base_b;
                sum += win[(dr + 1) * 3 + wc] * w;
                wsum += w;
            end
        end
        p = win[3 + ccol];
        low = (wsum != 0) ? sum / wsum : p;
        q = (ratio_q < usm_pkg::RATIO_MIN) ? usm_pkg::RATIO_MIN : ratio_q;
        num = q * int'(p) - (1024 - q) * int'(low);
        den = 2 * q - 1024;
        res = num / den;
        if (res < 0)
            res = 0;
        if (res > 255)
            res = 255;
        return res[7:0];
    endfunction

    function void note_input(bit m, logic [7:0] p);
        int unsigned x, r;
        bit          drain, got;
        logic [7:0]  pix, value;
        x = col;
        r = row;
        drain = r >= usm_pkg::HEIGHT;
        got = 0;
        value = '0;
        if (!drain && m)
            return;
        pix = drain ? 8'd0 : p;
        if (x == 0 && r >= 2)
        begin
            value = sharpen_at(2, r - 2, usm_pkg::WIDTH - 1);
            got = 1;
        end
        for (int k = 0; k < 3; k++)
        begin
            win[k * 3] = win[k * 3 + 1];
            win[k * 3 + 1] = win[k * 3 + 2];
        end
        win[2] = upper[x];
        win[5] = middle[x];
        win[8] = pix;
        upper[x] = middle[x];
        middle[x] = pix;
        if (x != 0 && r >= 1)
        begin
            value = sharpen_at(1, r - 1, x - 1);
            got = 1;
        end
        col = x + 1;
        if (col >= usm_pkg::WIDTH)
        begin
            col = 0;
            row = r + 1;
        end
        if (!got)
            return;
        produced_cnt++;
        pix_due.push_back(value);
        if (produced_cnt >= usm_pkg::WIDTH * usm_pkg::HEIGHT)
        begin
            last_due.push_back(1'b1);
            col = 0;
            row = 0;
            produced_cnt = 0;
        end
        else
        begin
            last_due.push_back(1'b0);
        end
    endfunction

    function void check_result(logic [7:0] p, logic l);
        logic [7:0] ep;
        bit         el;
        if (pix_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected word: pixel_out=%0d frame_last=%0b", p, l);
            return;
        end
        ep = pix_due.pop_front();
        el = last_due.pop_front();
        if (p !== ep || l !== el)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: pixel_out exp %0d got %0d, frame_last exp %0b got %0b",
                         ep, p, el, l);
        end
    endfunction

    function int unsigned pending();
        return pix_due.size();
    endfunction
endclass

module unsharp_mask_sharpener_test;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic                          mode;
    logic [7:0]                    pixel_in;
    logic                          out_valid;
    logic                          out_ready;
    logic [7:0]                    pixel_out;
    logic                          frame_last;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [usm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [usm_pkg::CFG_DAT_W-1:0] cfg_data;

    sharpen_board board;

    // idle percentages for sender and receiver; 0 gives back-to-back traffic
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned stall_hold;

    unsharp_mask_sharpener u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .pixel_in   (pixel_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_out  (pixel_out),
        .frame_last (frame_last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap(int unsigned pct);
        int unsigned r;
        r = $urandom_range(99);
        if (r >= pct)
            return 0;
        if ($urandom_range(15) == 0)
            return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    // Receiver: check at the edge, then pick the next ready level.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(pixel_out, frame_last);
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_hold <= 0;
        end
        else if (stall_hold != 0)
        begin
            stall_hold <= stall_hold - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            stall_hold <= pick_gap(recv_stall_pct);
            out_ready <= 1'b1;
        end
    end

    // One word on the input channel. valid is only lowered when a gap follows,
    // so a back-to-back word keeps it high through the step.
    task automatic send_word(bit m, logic [7:0] p);
        int unsigned gap;
        gap = pick_gap(send_idle_pct);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        pixel_in <= p;
        do @(posedge clk); while (!in_ready);
        board.note_input(m, p);
    endtask

    // Let every result come out, and let a word with no result finish too.
    task automatic settle();
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(logic [usm_pkg::CFG_IDX_W-1:0] idx,
                             logic [usm_pkg::CFG_DAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.set_reg(idx, val);
    endtask

    task automatic new_setting();
        logic [7:0]  b;
        logic [10:0] q;
        case ($urandom_range(5))
            0: b = 8'd1;
            1: b = 8'd255;
            2: b = 8'd0;
            default: b = 8'($urandom_range(255));
        endcase
        case ($urandom_range(6))
            0: q = 11'd513;
            1: q = 11'd1024;
            2: q = 11'($urandom_range(512));
            3: q = 11'd2047;
            default: q = 11'($urandom_range(513, 1024));
        endcase
        settle();
        write_reg(usm_pkg::CFG_BASE, 11'(b));
        write_reg(usm_pkg::CFG_RATIO, q);
    endtask

    function automatic logic [7:0] rand_pixel();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Fixed time limit; far above the slowest correct run.
    initial
    begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        board = new();
        board.clear();
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = 1'b0;
        pixel_in = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme registers, early flush words, extreme pixels.
        write_reg(usm_pkg::CFG_BASE, 11'd255);
        write_reg(usm_pkg::CFG_RATIO, 11'd1024);
        send_word(1'b1, 8'd77);
        send_word(1'b1, 8'd255);
        for (int i = 0; i < 20; i++)
            send_word(1'b0, (i % 2) ? 8'd255 : 8'd0);
        send_word(1'b1, 8'd0);

        // Random part with gaps on both sides; pause at each setting change.
        send_idle_pct = 30;
        recv_stall_pct = 30;
        for (int i = 0; i < 1320; i++)
        begin
            if (i % 264 == 0)
                new_setting();
            if ($urandom_range(19) == 0)
                send_word(1'b1, rand_pixel());
            send_word(1'b0, rand_pixel());
        end

        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (board.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
